[rtl/rbas_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbas_pkg
// Shared types, constants and helpers for the rigid body step unit.
// ----------------------------------------------------------------------------
package rbas_pkg;

    localparam int MAX_BODIES = 8;
    localparam int IDX_W      = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int CNT_W      = $clog2(MAX_BODIES + 1);

    localparam int ID_W      = 16;
    localparam int Q_W       = 32;
    localparam int H_W       = 31;
    localparam int FLAG_W    = 3;
    localparam int KIND_W    = 2;
    localparam int PAIR_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W  = 304;
    localparam int M_DATA_W  = 232;

    localparam int FLAG_STATIC = 0;
    localparam int FLAG_GRAV   = 1;
    localparam int FLAG_TRIG   = 2;

    typedef logic signed [Q_W-1:0] q_t;

    typedef struct packed {
        logic [ID_W-1:0]        id;
        logic [2:0][Q_W-1:0]    pos;
        logic [2:0][Q_W-1:0]    vel;
        logic [2:0][H_W-1:0]    half;
        logic [FLAG_W-1:0]      flags;
    } body_t;

    typedef enum logic [KIND_W-1:0] {
        IN_LOAD  = 2'd0,
        IN_STEP  = 2'd1,
        IN_CLEAR = 2'd2
    } in_kind_t;

    typedef enum logic [KIND_W-1:0] {
        RK_COLL  = 2'd0,
        RK_TRIG  = 2'd1,
        RK_STATE = 2'd2,
        RK_DONE  = 2'd3
    } res_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP = 2'd0,
        CFG_GRAV_X    = 2'd1,
        CFG_GRAV_Y    = 2'd2,
        CFG_GRAV_Z    = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_READ, OP_GET, OP_MUL, OP_SHF, OP_ACC, OP_WB,
        OP_DIFF, OP_TEST, OP_EVENT, OP_PEN, OP_CORR, OP_STATE, OP_DONE
    } op_t;

    typedef struct packed {
        op_t             op;
        logic [IDX_W-1:0] addr_a;
        logic [IDX_W-1:0] addr_b;
        logic [1:0]       axis;
        logic             to_pos;
    } cmd_t;

    typedef struct packed {
        logic static_a;
        logic grav_a;
        logic overlap;
        logic out_free;
    } sts_t;

    function automatic q_t sat_q(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return x[Q_W-1:0];
        end
    endfunction

endpackage

[rtl/rigid_body_aabb_step_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rigid_body_aabb_step_unit
// Body table with fixed-step integration and box overlap events.
// ----------------------------------------------------------------------------
// Load and clear complete without leaving idle. A step integrates each non-static
// body through one shared multiplier (velocity from gravity first when enabled),
// tests every body pair for overlap and emits an event for each overlapping pair,
// then a state item per body and a done item; output stalls hold the walk, and input waits until done.
// Synchronous active-low reset clears control and restores register defaults.
module rigid_body_aabb_step_unit
    import rbas_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // body_id, pos_x/y/z, vel_x/y/z, half_x/y/z, flags
    input  logic [S_DATA_W-1:0]   s_tdata,
    // kind
    input  logic [KIND_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // first_id, second_id, out_pos_x/y/z, out_vel_x/y/z, pair_count, zero pad
    output logic [M_DATA_W-1:0]   m_tdata,
    // result_kind
    output logic [KIND_W-1:0]     m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [Q_W-1:0]        cfg_wdata
);
    cmd_t cmd;
    sts_t sts;

    rbas_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    rbas_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

[rtl/rbas_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbas_ctrl
// Sequencer: loads, integration walk, pair walk, state dump and done item.
// ----------------------------------------------------------------------------
module rbas_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [rbas_pkg::KIND_W-1:0] s_tuser,
    input  rbas_pkg::sts_t            sts,
    output rbas_pkg::cmd_t            cmd
);
    import rbas_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_INT_RD, S_INT_GET, S_INT_MUL, S_INT_SHF, S_INT_ACC, S_INT_WB,
        S_PR_RD, S_PR_DIFF, S_PR_TEST, S_PR_EVENT, S_PR_PEN, S_PR_CORR,
        S_ST_RD, S_ST_OUT, S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [1:0]       axis_reg, axis_next;
    logic             to_pos_reg, to_pos_next;
    logic [CNT_W-1:0] i_inc, i_inc2, j_inc;

    assign s_tready = (state_reg == S_IDLE);
    assign i_inc    = i_reg + CNT_W'(1);
    assign i_inc2   = i_reg + CNT_W'(2);
    assign j_inc    = j_reg + CNT_W'(1);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        axis_next   = axis_reg;
        to_pos_next = to_pos_reg;
        cmd.op      = OP_NONE;
        cmd.addr_a  = i_reg[IDX_W-1:0];
        cmd.addr_b  = j_reg[IDX_W-1:0];
        cmd.axis    = axis_reg;
        cmd.to_pos  = to_pos_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    unique case (s_tuser)
                        IN_LOAD: begin
                            if (count_reg < CNT_W'(MAX_BODIES)) begin
                                cmd.op     = OP_LOAD;
                                cmd.addr_a = count_reg[IDX_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        IN_STEP: begin
                            i_next = '0;
                            if (count_reg == '0) begin
                                state_next = S_DONE;
                            end else begin
                                state_next = S_INT_RD;
                            end
                        end
                        IN_CLEAR: count_next = '0;
                        default: ;
                    endcase
                end
            end
            S_INT_RD: begin
                cmd.op     = OP_READ;
                state_next = S_INT_GET;
            end
            S_INT_GET, S_INT_WB: begin
                if (state_reg == S_INT_GET) begin
                    cmd.op = OP_GET;
                end else begin
                    cmd.op = OP_WB;
                end
                if (state_reg == S_INT_GET && !sts.static_a) begin
                    axis_next   = 2'd0;
                    to_pos_next = !sts.grav_a;
                    state_next  = S_INT_MUL;
                end else if (i_inc != count_reg) begin
                    i_next     = i_inc;
                    state_next = S_INT_RD;
                end else if (count_reg < CNT_W'(2)) begin
                    i_next     = '0;
                    state_next = S_ST_RD;
                end else begin
                    i_next     = '0;
                    j_next     = CNT_W'(1);
                    state_next = S_PR_RD;
                end
            end
            S_INT_MUL: begin
                cmd.op     = OP_MUL;
                state_next = S_INT_SHF;
            end
            S_INT_SHF: begin
                cmd.op     = OP_SHF;
                state_next = S_INT_ACC;
            end
            S_INT_ACC: begin
                cmd.op = OP_ACC;
                if (axis_reg != 2'd2) begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_INT_MUL;
                end else if (!to_pos_reg) begin
                    axis_next   = 2'd0;
                    to_pos_next = 1'b1;
                    state_next  = S_INT_MUL;
                end else begin
                    state_next = S_INT_WB;
                end
            end
            S_PR_RD: begin
                cmd.op     = OP_READ;
                state_next = S_PR_DIFF;
            end
            S_PR_DIFF: begin
                cmd.op     = OP_DIFF;
                state_next = S_PR_TEST;
            end
            S_PR_TEST: begin
                cmd.op     = OP_TEST;
                state_next = S_PR_EVENT;
            end
            S_PR_EVENT, S_PR_CORR: begin
                if (state_reg == S_PR_EVENT && sts.overlap) begin
                    if (sts.out_free) begin
                        cmd.op     = OP_EVENT;
                        state_next = S_PR_PEN;
                    end
                end else begin
                    if (state_reg == S_PR_CORR) begin
                        cmd.op = OP_CORR;
                    end
                    if (j_inc != count_reg) begin
                        j_next     = j_inc;
                        state_next = S_PR_RD;
                    end else if (i_inc2 == count_reg) begin
                        i_next     = '0;
                        state_next = S_ST_RD;
                    end else begin
                        i_next     = i_inc;
                        j_next     = i_inc2;
                        state_next = S_PR_RD;
                    end
                end
            end
            S_PR_PEN: begin
                cmd.op     = OP_PEN;
                state_next = S_PR_CORR;
            end
            S_ST_RD: begin
                cmd.op     = OP_READ;
                state_next = S_ST_OUT;
            end
            S_ST_OUT: begin
                if (sts.out_free) begin
                    cmd.op = OP_STATE;
                    if (i_inc == count_reg) begin
                        state_next = S_DONE;
                    end else begin
                        i_next     = i_inc;
                        state_next = S_ST_RD;
                    end
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.op     = OP_DONE;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            axis_reg   <= '0;
            to_pos_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            axis_reg   <= axis_next;
            to_pos_reg <= to_pos_next;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_BODIES))
        else $error("body count above table size");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PR_RD || state_reg == S_PR_DIFF || state_reg == S_PR_TEST)
        |-> (j_reg > i_reg && j_reg < count_reg))
        else $error("pair indices out of order");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_EVENT || cmd.op == OP_STATE || cmd.op == OP_DONE)
        |-> sts.out_free)
        else $error("result issued while output register busy");

    a_step_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && sts.out_free) |=> (state_reg == S_IDLE))
        else $error("done item did not end the step");
`endif

endmodule

[rtl/rbas_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbas_dp
// Body table, integrator, pair tester and output register.
// ----------------------------------------------------------------------------
module rbas_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rbas_pkg::cmd_t                cmd,
    output rbas_pkg::sts_t                sts,
    input  logic [rbas_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          cfg_wr_en,
    input  logic [rbas_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rbas_pkg::Q_W-1:0]      cfg_wdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rbas_pkg::M_DATA_W-1:0] m_tdata,
    output logic [rbas_pkg::KIND_W-1:0]   m_tuser,
    output logic                          m_tlast
);
    import rbas_pkg::*;

    body_t mem [MAX_BODIES];
    body_t rd_a_reg, rd_b_reg, w_reg;
    body_t in_body, wb_body, corr_body, wr_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;

    logic [H_W-1:0]          ts_reg;
    logic [2:0][Q_W-1:0]     grav_reg;
    logic signed [63:0]      prod_reg;
    q_t                      q_reg;
    logic [2:0][Q_W:0]       dabs_reg;
    logic [2:0][Q_W-1:0]     ext_reg;
    logic [2:0][Q_W-1:0]     pen_reg;
    logic                    dy_neg_reg, ovl_reg, trig_reg, sl_reg, sr_reg, corr_reg;
    logic signed [Q_W+1:0]   shift_reg;
    logic [PAIR_W-1:0]       pair_cnt_reg;

    logic                    m_valid_reg;
    logic [M_DATA_W-1:0]     m_data_reg, m_data_next;
    logic [KIND_W-1:0]       m_user_reg, m_user_next;
    logic                    m_last_reg, out_load;

    q_t                      mul_a, acc_t;
    logic signed [63:0]      acc_sum;
    logic signed [Q_W:0]     d_k [3];

    always_comb begin
        in_body.id    = s_tdata[ID_W-1:0];
        for (int k = 0; k < 3; k++) begin
            in_body.pos[k]  = s_tdata[16 + 32*k +: Q_W];
            in_body.vel[k]  = s_tdata[112 + 32*k +: Q_W];
            in_body.half[k] = s_tdata[208 + 31*k +: H_W];
        end
        in_body.flags = s_tdata[301 +: FLAG_W];
    end

    // ground clamp on write back
    always_comb begin
        wb_body = w_reg;
        if ($signed(w_reg.pos[1]) < $signed({1'b0, w_reg.half[1]})) begin
            wb_body.pos[1] = {1'b0, w_reg.half[1]};
            wb_body.vel[1] = '0;
        end
    end

    always_comb begin
        if (sl_reg) begin
            corr_body        = rd_b_reg;
            corr_body.pos[1] = sat_q(64'($signed(rd_b_reg.pos[1])) - 64'(shift_reg));
        end else begin
            corr_body        = rd_a_reg;
            corr_body.pos[1] = sat_q(64'($signed(rd_a_reg.pos[1])) + 64'(shift_reg));
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cmd.addr_a;
        wr_data = in_body;
        case (cmd.op)
            OP_LOAD: wr_en = 1'b1;
            OP_WB: begin
                wr_en   = 1'b1;
                wr_data = wb_body;
            end
            OP_CORR: begin
                wr_en   = corr_reg;
                wr_data = corr_body;
                if (sl_reg) begin
                    wr_addr = cmd.addr_b;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.op == OP_READ) begin
            rd_a_reg <= mem[cmd.addr_a];
            rd_b_reg <= mem[cmd.addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ts_reg   <= H_W'(1092);
            grav_reg <= {32'sd0, -32'sd642908, 32'sd0};
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TIME_STEP: ts_reg      <= cfg_wdata[H_W-1:0];
                CFG_GRAV_X:    grav_reg[0] <= cfg_wdata;
                CFG_GRAV_Y:    grav_reg[1] <= cfg_wdata;
                CFG_GRAV_Z:    grav_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign mul_a   = cmd.to_pos ? w_reg.vel[cmd.axis] : grav_reg[cmd.axis];
    assign acc_t   = cmd.to_pos ? w_reg.pos[cmd.axis] : w_reg.vel[cmd.axis];
    assign acc_sum = 64'(acc_t) + 64'(q_reg);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d_k[k] = $signed({rd_a_reg.pos[k][Q_W-1], rd_a_reg.pos[k]})
                   - $signed({rd_b_reg.pos[k][Q_W-1], rd_b_reg.pos[k]});
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_GET: w_reg <= rd_a_reg;
            OP_MUL: prod_reg <= 64'(mul_a) * 64'($signed({1'b0, ts_reg}));
            OP_SHF: q_reg <= sat_q(prod_reg >>> 16);
            OP_ACC: begin
                if (cmd.to_pos) begin
                    w_reg.pos[cmd.axis] <= sat_q(acc_sum);
                end else begin
                    w_reg.vel[cmd.axis] <= sat_q(acc_sum);
                end
            end
            OP_DIFF: begin
                for (int k = 0; k < 3; k++) begin
                    dabs_reg[k] <= d_k[k][Q_W] ? (Q_W+1)'(-d_k[k]) : d_k[k];
                    ext_reg[k]  <= {1'b0, rd_a_reg.half[k]} + {1'b0, rd_b_reg.half[k]};
                end
                dy_neg_reg <= d_k[1][Q_W];
            end
            OP_TEST: begin
                ovl_reg <= (dabs_reg[0] <= {1'b0, ext_reg[0]})
                        && (dabs_reg[1] <= {1'b0, ext_reg[1]})
                        && (dabs_reg[2] <= {1'b0, ext_reg[2]});
                for (int k = 0; k < 3; k++) begin
                    pen_reg[k] <= ext_reg[k] - dabs_reg[k][Q_W-1:0];
                end
                trig_reg <= rd_a_reg.flags[FLAG_TRIG] | rd_b_reg.flags[FLAG_TRIG];
                sl_reg   <= rd_a_reg.flags[FLAG_STATIC];
                sr_reg   <= rd_b_reg.flags[FLAG_STATIC];
            end
            OP_PEN: begin
                corr_reg  <= !trig_reg && (sl_reg ^ sr_reg)
                          && (pen_reg[1] <= pen_reg[0]) && (pen_reg[1] <= pen_reg[2]);
                shift_reg <= dy_neg_reg ? -$signed({2'b00, pen_reg[1]})
                                        : $signed({2'b00, pen_reg[1]});
            end
            default: ;
        endcase
    end

    always_comb begin
        m_data_next = '0;
        m_user_next = RK_DONE;
        out_load    = 1'b1;
        case (cmd.op)
            OP_EVENT: begin
                m_user_next        = trig_reg ? RK_TRIG : RK_COLL;
                m_data_next[15:0]  = rd_a_reg.id;
                m_data_next[31:16] = rd_b_reg.id;
            end
            OP_STATE: begin
                m_user_next       = RK_STATE;
                m_data_next[15:0] = rd_a_reg.id;
                for (int k = 0; k < 3; k++) begin
                    m_data_next[32 + 32*k +: Q_W]  = rd_a_reg.pos[k];
                    m_data_next[128 + 32*k +: Q_W] = rd_a_reg.vel[k];
                end
            end
            OP_DONE: m_data_next[224 +: PAIR_W] = pair_cnt_reg;
            default: out_load = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            pair_cnt_reg <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.op == OP_EVENT) begin
                pair_cnt_reg <= pair_cnt_reg + PAIR_W'(1);
            end else if (cmd.op == OP_DONE) begin
                pair_cnt_reg <= '0;
            end
        end
        if (out_load) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
            m_last_reg <= (cmd.op == OP_DONE);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    assign sts.static_a = rd_a_reg.flags[FLAG_STATIC];
    assign sts.grav_a   = rd_a_reg.flags[FLAG_GRAV];
    assign sts.overlap  = ovl_reg;
    assign sts.out_free = !m_valid_reg || m_tready;

endmodule

[sim/tb_rigid_body_aabb_step_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rigid_body_aabb_step_unit
// Drives load, step and clear transfers into the rigid body step unit with
// random gaps and output stalls. A scoreboard predicts the integration,
// overlap events, body states and done items, and checks every output
// transfer field by field in order. Gravity and time step are reprogrammed
// between phases.
// ----------------------------------------------------------------------------
module tb_rigid_body_aabb_step_unit;
    import rbas_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] id1;
        logic [15:0] id2;
        logic [31:0] pv [6];
        logic [5:0]  pairs;
        logic        last;
    } outcome_t;

    class body_scoreboard;
        logic [30:0] dt;
        logic signed [31:0] grav [3];
        int count;
        logic [15:0] ids [MAX_BODIES];
        logic signed [31:0] pos [MAX_BODIES][3];
        logic signed [31:0] vel [MAX_BODIES][3];
        logic [30:0] half [MAX_BODIES][3];
        logic [2:0] flg [MAX_BODIES];
        outcome_t pending [$];
        int errors;
        int shown;

        function new();
            dt = 31'd1092;
            grav[0] = 0;
            grav[1] = -32'sd642908;
            grav[2] = 0;
            count = 0;
            errors = 0;
            shown = 0;
        endfunction

        function logic signed [31:0] sat(logic signed [63:0] x);
            if (x > 64'sd2147483647) return 32'sh7fffffff;
            if (x < -64'sd2147483648) return 32'sh80000000;
            return x[31:0];
        endfunction

        function logic signed [31:0] scale(logic signed [31:0] a);
            logic signed [63:0] p;
            p = 64'(a) * $signed({33'd0, dt});
            return sat(p >>> 16);
        endfunction

        function void set_reg(cfg_idx_t idx, logic [31:0] v);
            case (idx)
                CFG_TIME_STEP: dt = v[30:0];
                CFG_GRAV_X: grav[0] = v;
                CFG_GRAV_Y: grav[1] = v;
                default: grav[2] = v;
            endcase
        endfunction

        function void push_out(logic [1:0] k, logic [15:0] a, logic [15:0] b, int slot,
                               logic [5:0] pc, logic l);
            outcome_t o;
            o.kind = k;
            o.id1 = a;
            o.id2 = b;
            for (int c = 0; c < 3; c++) begin
                o.pv[c] = (slot >= 0) ? pos[slot][c] : 0;
                o.pv[c+3] = (slot >= 0) ? vel[slot][c] : 0;
            end
            o.pairs = pc;
            o.last = l;
            pending = {pending, o};
        endfunction

        function void note_input(in_kind_t k, logic [S_DATA_W-1:0] d);
            logic signed [63:0] dd [3];
            logic signed [63:0] ee [3];
            logic signed [63:0] ad [3];
            logic signed [63:0] sh;
            int pc;
            bit trig, sl, sr;
            if (k == IN_CLEAR) begin
                count = 0;
                return;
            end
            if (k == IN_LOAD) begin
                if (count < MAX_BODIES) begin
                    ids[count] = d[15:0];
                    for (int c = 0; c < 3; c++) begin
                        pos[count][c] = d[16 + 32*c +: 32];
                        vel[count][c] = d[112 + 32*c +: 32];
                        half[count][c] = d[208 + 31*c +: 31];
                    end
                    flg[count] = d[301 +: 3];
                    count++;
                end
                return;
            end
            if (k != IN_STEP) return;
            for (int i = 0; i < count; i++) begin
                if (flg[i][FLAG_STATIC]) continue;
                for (int c = 0; c < 3; c++) begin
                    if (flg[i][FLAG_GRAV]) vel[i][c] = sat(64'(vel[i][c]) + scale(grav[c]));
                end
                for (int c = 0; c < 3; c++) pos[i][c] = sat(64'(pos[i][c]) + scale(vel[i][c]));
                if (pos[i][1] < $signed({1'b0, half[i][1]})) begin
                    pos[i][1] = {1'b0, half[i][1]};
                    vel[i][1] = 0;
                end
            end
            pc = 0;
            for (int i = 0; i < count; i++) begin
                for (int j = i + 1; j < count; j++) begin
                    for (int c = 0; c < 3; c++) begin
                        dd[c] = 64'(pos[i][c]) - 64'(pos[j][c]);
                        ad[c] = dd[c] < 0 ? -dd[c] : dd[c];
                        ee[c] = 64'(half[i][c]) + 64'(half[j][c]);
                    end
                    if (ad[0] > ee[0] || ad[1] > ee[1] || ad[2] > ee[2]) continue;
                    pc++;
                    trig = flg[i][FLAG_TRIG] | flg[j][FLAG_TRIG];
                    push_out(trig ? RK_TRIG : RK_COLL, ids[i], ids[j], -1, 0, 0);
                    sl = flg[i][FLAG_STATIC];
                    sr = flg[j][FLAG_STATIC];
                    if (trig || (sl && sr)) continue;
                    if (ee[1] - ad[1] <= ee[0] - ad[0] && ee[1] - ad[1] <= ee[2] - ad[2]) begin
                        sh = dd[1] >= 0 ? ee[1] - ad[1] : ad[1] - ee[1];
                        if (sl) pos[j][1] = sat(64'(pos[j][1]) - sh);
                        else if (sr) pos[i][1] = sat(64'(pos[i][1]) + sh);
                    end
                end
            end
            for (int i = 0; i < count; i++) push_out(RK_STATE, ids[i], 0, i, 0, 0);
            push_out(RK_DONE, 0, 0, -1, pc[5:0], 1);
        endfunction

        function void check_result(logic [1:0] u, logic [M_DATA_W-1:0] d, logic l);
            outcome_t e;
            logic [M_DATA_W-1:0] want;
            if (pending.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("unexpected transfer kind=%0d data=%h", u, d);
                end
                return;
            end
            e = pending.pop_front();
            want = '0;
            want[15:0] = e.id1;
            want[31:16] = e.id2;
            for (int c = 0; c < 6; c++) want[32 + 32*c +: 32] = e.pv[c];
            want[224 +: 6] = e.pairs;
            if (u !== e.kind || d !== want || l !== e.last) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("mismatch: exp kind=%0d last=%0d data=%h", e.kind, e.last, want);
                    $display("          got kind=%0d last=%0d data=%h", u, l, d);
                end
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0] m_tuser;
    logic m_tlast;
    logic cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [Q_W-1:0] cfg_wdata = '0;

    body_scoreboard board;
    bit hold_off = 0;

    rigid_body_aabb_step_unit u_dut (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // Output side: random stall per transfer, plus a long hold-off on request.
    initial begin
        int w;
        forever begin
            @(negedge aclk);
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (w != 0 || hold_off) begin
                m_tready <= 0;
                repeat (w) @(negedge aclk);
                while (hold_off) @(negedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            board.check_result(m_tuser, m_tdata, m_tlast);
        end
    end

    // Hold valid after a transfer until the next item or an idle gap replaces it.
    task automatic send(in_kind_t k, logic [S_DATA_W-1:0] d, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= k;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_input(k, d);
        @(negedge aclk);
    endtask

    function automatic logic [S_DATA_W-1:0] pack_body(logic [15:0] id, logic [31:0] p [3],
            logic [31:0] v [3], logic [30:0] h [3], logic [2:0] f);
        logic [S_DATA_W-1:0] d;
        d = '0;
        d[15:0] = id;
        for (int c = 0; c < 3; c++) begin
            d[16 + 32*c +: 32] = p[c];
            d[112 + 32*c +: 32] = v[c];
            d[208 + 31*c +: 31] = h[c];
        end
        d[301 +: 3] = f;
        return d;
    endfunction

    function automatic logic [31:0] rnd_q(bit wide);
        if (wide) return $urandom;
        return $signed($urandom_range(0, 20 << 16)) - (32'sd10 << 16);
    endfunction

    task automatic load_random(bit wide, bit no_gap);
        logic [31:0] p [3];
        logic [31:0] v [3];
        logic [30:0] h [3];
        for (int c = 0; c < 3; c++) begin
            p[c] = rnd_q(wide);
            v[c] = wide ? $urandom : rnd_q(0);
            h[c] = wide ? 31'($urandom) : 31'($urandom_range(1 << 15, 4 << 16));
        end
        send(IN_LOAD, pack_body(16'($urandom), p, v, h, 3'($urandom_range(0, 7))), no_gap);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= v;
        board.set_reg(idx, v);
        @(negedge aclk);
        cfg_wr_en <= 0;
    endtask

    task automatic settle();
        int guard;
        guard = 0;
        s_tvalid <= 0;
        while (board.pending.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (2000) @(negedge aclk);
    endtask

    initial begin
        logic [31:0] p [3];
        logic [31:0] v [3];
        logic [30:0] h [3];
        logic [31:0] zq [3];
        logic [30:0] mh [3];
        board = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Directed: empty step, ground clamp, static/dynamic push, trigger, full table.
        send(IN_STEP, '0, 0);
        zq = '{0, 0, 0};
        mh = '{31'h7fffffff, 31'h7fffffff, 31'h7fffffff};
        p = '{0, 32'h0001_0000, 0};
        h = '{31'h0002_0000, 31'h0001_0000, 31'h0002_0000};
        send(IN_LOAD, pack_body(16'h0011, p, zq, h, 3'b001), 0);
        p = '{32'h0000_8000, 32'h0002_8000, 0};
        v = '{0, 32'hffff_0000, 0};
        send(IN_LOAD, pack_body(16'h0022, p, v, h, 3'b010), 0);
        p = '{0, 32'h0001_0000, 0};
        send(IN_LOAD, pack_body(16'h0033, p, zq, h, 3'b100), 0);
        p = '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000};
        v = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
        send(IN_LOAD, pack_body(16'hffff, p, v, mh, 3'b010), 0);
        send(IN_LOAD, pack_body(16'h0000, p, v, mh, 3'b111), 0);
        send(IN_STEP, '0, 0);
        for (int i = 0; i < 4; i++) load_random(0, 0);
        send(IN_STEP, '0, 0);
        send(IN_CLEAR, '0, 0);
        send(IN_STEP, '0, 0);
        settle();

        write_reg(CFG_TIME_STEP, 32'h7fff_ffff);
        write_reg(CFG_GRAV_X, 32'h7fff_ffff);
        write_reg(CFG_GRAV_Y, 32'h8000_0000);
        write_reg(CFG_GRAV_Z, 32'h8000_0000);
        for (int i = 0; i < 3; i++) load_random(1, 0);
        send(IN_STEP, '0, 0);
        send(IN_CLEAR, '0, 0);

        // Long output hold-off while steps keep coming.
        for (int i = 0; i < 6; i++) load_random(0, 1);
        hold_off = 1;
        fork
            begin
                repeat (3000) @(negedge aclk);
                hold_off = 0;
            end
            for (int i = 0; i < 4; i++) send(IN_STEP, '0, 1);
        join
        settle();

        for (int phase = 0; phase < 4; phase++) begin
            write_reg(CFG_TIME_STEP, phase == 0 ? 32'd0 : $urandom_range(1, 40000));
            write_reg(CFG_GRAV_X, phase == 3 ? $urandom : rnd_q(0));
            write_reg(CFG_GRAV_Y, phase == 1 ? 32'h7fff_ffff : rnd_q(0));
            write_reg(CFG_GRAV_Z, phase == 3 ? $urandom : rnd_q(0));
            for (int it = 0; it < 60; it++) begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 55) load_random($urandom_range(0, 9) == 0, $urandom_range(0, 3) == 0);
                else if (r < 85) send(IN_STEP, S_DATA_W'($urandom), 0);
                else if (r < 95) send(IN_CLEAR, '0, 0);
                else send(in_kind_t'(2'd3), S_DATA_W'({$urandom, $urandom}), 0);
            end
            send(IN_STEP, '0, 0);
            settle();
        end

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
